@@ hw/rtl/brc_pkg.sv @@
package brc_pkg;

  // Pixel and limit widths
  localparam int CH_BITS    = 8;
  localparam int LIMIT_BITS = 10;
  localparam int LANES      = 3;

  // Derived widths: channel sum, scaled divisor, running remainder, product
  localparam int SUM_BITS   = CH_BITS + 2;
  localparam int DSR_BITS   = SUM_BITS + CH_BITS - 1;
  localparam int REM_BITS   = DSR_BITS + 1;
  localparam int PROD_BITS  = CH_BITS + LIMIT_BITS;
  localparam int MUL_BITS   = (PROD_BITS > REM_BITS) ? PROD_BITS : REM_BITS;
  localparam int CMP_BITS   = (SUM_BITS > LIMIT_BITS) ? SUM_BITS : LIMIT_BITS;

  // One divider stage for each quotient bit
  localparam int DIV_STAGES = CH_BITS;

  // Lane numbering inside a pixel word
  localparam int LANE_RED   = 0;
  localparam int LANE_GREEN = 1;
  localparam int LANE_BLUE  = 2;

  typedef logic [CH_BITS-1:0]    chan_t;
  typedef logic [LIMIT_BITS-1:0] limit_t;
  typedef logic [SUM_BITS-1:0]   sum_t;
  typedef logic [DSR_BITS-1:0]   dsr_t;
  typedef logic [REM_BITS-1:0]   rem_t;
  typedef logic [MUL_BITS-1:0]   mul_t;

  localparam limit_t LIMIT_RESET = limit_t'(255);

  // Word that travels down the divider pipeline
  typedef struct packed {
    logic                    scaled;
    chan_t [LANES-1:0]       chan;
    rem_t  [LANES-1:0]       rem;
    chan_t [LANES-1:0]       quot;
    dsr_t                    dsr;
  } div_word_t;

endpackage

@@ hw/rtl/brc_if.sv @@
// Input pixel channel
interface brc_pix_if;
  import brc_pkg::*;

  logic  valid;
  logic  ready;
  chan_t red_in;
  chan_t green_in;
  chan_t blue_in;

  modport source (output valid, output red_in, output green_in, output blue_in, input ready);
  modport sink   (input valid, input red_in, input green_in, input blue_in, output ready);
endinterface

// Result pixel channel
interface brc_res_if;
  import brc_pkg::*;

  logic  valid;
  logic  ready;
  chan_t red_out;
  chan_t green_out;
  chan_t blue_out;
  logic  was_scaled;

  modport source (output valid, output red_out, output green_out, output blue_out,
                  output was_scaled, input ready);
  modport sink   (input valid, input red_out, input green_out, input blue_out,
                  input was_scaled, output ready);
endinterface

@@ hw/rtl/brc_front.sv @@
module brc_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               up_vld,
  output logic               up_rdy,
  input  brc_pkg::chan_t     red,
  input  brc_pkg::chan_t     green,
  input  brc_pkg::chan_t     blue,
  input  brc_pkg::limit_t    limit,
  output logic               dn_vld,
  input  logic               dn_rdy,
  output brc_pkg::div_word_t dn_word
);
  import brc_pkg::*;

  // First stage: channel sum and the over-limit decision
  logic                a_vld_r, a_vld_nxt;
  logic                a_rdy;
  chan_t [LANES-1:0]   a_chan_r, a_chan_nxt;
  limit_t              a_limit_r, a_limit_nxt;
  sum_t                a_sum_r, a_sum_nxt;
  logic                a_scaled_r, a_scaled_nxt;
  sum_t                sum_c;

  // Second stage: products and the starting divider word
  logic                b_vld_r, b_vld_nxt;
  logic                b_rdy;
  div_word_t           b_word_r, b_word_nxt;
  mul_t  [LANES-1:0]   prod_c;

  assign sum_c = sum_t'(red) + sum_t'(green) + sum_t'(blue);

  // Stage A takes a word when empty or when stage B moves on
  always_comb begin
    a_rdy        = !a_vld_r || b_rdy;
    a_vld_nxt    = a_rdy ? up_vld : a_vld_r;
    a_chan_nxt   = a_chan_r;
    a_limit_nxt  = a_limit_r;
    a_sum_nxt    = a_sum_r;
    a_scaled_nxt = a_scaled_r;
    if (a_rdy && up_vld) begin
      a_chan_nxt[LANE_RED]   = red;
      a_chan_nxt[LANE_GREEN] = green;
      a_chan_nxt[LANE_BLUE]  = blue;
      a_limit_nxt            = limit;
      a_sum_nxt              = sum_c;
      a_scaled_nxt           = CMP_BITS'(sum_c) > CMP_BITS'(limit);
    end
  end

  assign up_rdy = a_rdy;

  // Each channel times the limit; the remainder starts at that product
  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      prod_c[k] = mul_t'(a_chan_r[k]) * mul_t'(a_limit_r);
    end
  end

  always_comb begin
    b_rdy      = !b_vld_r || dn_rdy;
    b_vld_nxt  = b_rdy ? a_vld_r : b_vld_r;
    b_word_nxt = b_word_r;
    if (b_rdy && a_vld_r) begin
      b_word_nxt.scaled = a_scaled_r;
      b_word_nxt.chan   = a_chan_r;
      b_word_nxt.dsr    = {a_sum_r, {(CH_BITS-1){1'b0}}};
      for (int k = 0; k < LANES; k++) begin
        // A pass-through pixel carries a zero remainder to keep the divider tidy
        b_word_nxt.rem[k]  = a_scaled_r ? prod_c[k][REM_BITS-1:0] : '0;
        b_word_nxt.quot[k] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
    end else begin
      a_vld_r <= a_vld_nxt;
      b_vld_r <= b_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_chan_r   <= a_chan_nxt;
    a_limit_r  <= a_limit_nxt;
    a_sum_r    <= a_sum_nxt;
    a_scaled_r <= a_scaled_nxt;
    b_word_r   <= b_word_nxt;
  end

  assign dn_vld  = b_vld_r;
  assign dn_word = b_word_r;

  // A word marked for scaling always has a sum above zero
  a_scaled_sum : assert property (@(posedge clk) disable iff (!rst_n)
    b_vld_r && b_word_r.scaled |-> b_word_r.dsr != '0)
    else $error("scaled word with zero divisor");

  // Stage A is never left holding a word that stage B could have taken
  a_front_flow : assert property (@(posedge clk) disable iff (!rst_n)
    a_vld_r && !b_vld_r |=> b_vld_r)
    else $error("front pipeline failed to advance");

  // Stalled downstream with both stages full keeps the input closed
  a_front_full : assert property (@(posedge clk) disable iff (!rst_n)
    a_vld_r && b_vld_r && !dn_rdy |-> !up_rdy)
    else $error("front accepted a word while full and stalled");

endmodule

@@ hw/rtl/brc_div_stage.sv @@
module brc_div_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               up_vld,
  output logic               up_rdy,
  input  brc_pkg::div_word_t up_word,
  output logic               dn_vld,
  input  logic               dn_rdy,
  output brc_pkg::div_word_t dn_word
);
  import brc_pkg::*;

  logic              vld_r, vld_nxt;
  div_word_t         word_r, word_nxt;
  logic [LANES-1:0]  take;
  rem_t [LANES-1:0]  diff;

  // One restoring step per lane: compare against the scaled sum, subtract, shift
  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      take[k] = up_word.rem[k] >= {1'b0, up_word.dsr};
      diff[k] = up_word.rem[k] - (take[k] ? {1'b0, up_word.dsr} : '0);
    end
  end

  always_comb begin
    up_rdy   = !vld_r || dn_rdy;
    vld_nxt  = up_rdy ? up_vld : vld_r;
    word_nxt = word_r;
    if (up_rdy && up_vld) begin
      word_nxt = up_word;
      for (int k = 0; k < LANES; k++) begin
        word_nxt.rem[k]  = {diff[k][DSR_BITS-1:0], 1'b0};
        word_nxt.quot[k] = {up_word.quot[k][CH_BITS-2:0], take[k]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign dn_vld  = vld_r;
  assign dn_word = word_r;

  // The remainder stays below twice the scaled divisor, else a quotient bit was lost
  for (genvar k = 0; k < LANES; k++) begin : g_chk
    a_rem_bound : assert property (@(posedge clk) disable iff (!rst_n)
      vld_r && word_r.scaled |-> word_r.rem[k] < {word_r.dsr, 1'b0})
      else $error("divider remainder out of range");
  end

endmodule

@@ hw/rtl/rgb_total_brightness_clamp_unit.sv @@
// Channel  Dir  Handshake          Word
// in_ch    in   valid/ready        red_in, green_in, blue_in
// out_ch   out  valid/ready        red_out, green_out, blue_out, was_scaled
// cfg      in   cfg_we (no ready)  cfg_data = clamp_limit
//
// One pixel enters per cycle unless every stage is full behind a stalled
// output. A taken pixel passes two front stages, then one divider stage per
// quotient bit. Reset is synchronous and clears all valid bits; the
// limit returns to 255. Each stage holds its word while the one after it is
// full and stalled, so empty stages fill up behind a stalled output.
module rgb_total_brightness_clamp_unit (
  input  logic              clk,
  input  logic              rst_n,
  brc_pix_if.sink           in_ch,
  brc_res_if.source         out_ch,
  input  logic              cfg_we,
  input  brc_pkg::limit_t   cfg_data
);
  import brc_pkg::*;

  limit_t                      clamp_limit_r, clamp_limit_nxt;
  logic      [DIV_STAGES:0]    vld;
  logic      [DIV_STAGES:0]    rdy;
  div_word_t [DIV_STAGES:0]    word;
  div_word_t                   last;

  // Limit register
  assign clamp_limit_nxt = cfg_we ? cfg_data : clamp_limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clamp_limit_r <= LIMIT_RESET;
    end else begin
      clamp_limit_r <= clamp_limit_nxt;
    end
  end

  // Sum, compare and multiply
  brc_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .up_vld  (in_ch.valid),
    .up_rdy  (in_ch.ready),
    .red     (in_ch.red_in),
    .green   (in_ch.green_in),
    .blue    (in_ch.blue_in),
    .limit   (clamp_limit_r),
    .dn_vld  (vld[0]),
    .dn_rdy  (rdy[0]),
    .dn_word (word[0])
  );

  // Divider, one quotient bit per stage
  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
    brc_div_stage u_stage (
      .clk     (clk),
      .rst_n   (rst_n),
      .up_vld  (vld[s]),
      .up_rdy  (rdy[s]),
      .up_word (word[s]),
      .dn_vld  (vld[s+1]),
      .dn_rdy  (rdy[s+1]),
      .dn_word (word[s+1])
    );
  end

  // Result word: quotient for scaled pixels, original channels otherwise
  assign last                = word[DIV_STAGES];
  assign rdy[DIV_STAGES]     = out_ch.ready;
  assign out_ch.valid        = vld[DIV_STAGES];
  assign out_ch.was_scaled   = last.scaled;
  assign out_ch.red_out      = last.scaled ? last.quot[LANE_RED]   : last.chan[LANE_RED];
  assign out_ch.green_out    = last.scaled ? last.quot[LANE_GREEN] : last.chan[LANE_GREEN];
  assign out_ch.blue_out     = last.scaled ? last.quot[LANE_BLUE]  : last.chan[LANE_BLUE];

  // A ready output opens the whole pipeline back to the input
  a_ready_chain : assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.ready |-> in_ch.ready)
    else $error("input closed while output is ready");

  // No result word straight after reset
  a_reset_empty : assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("result word valid after reset");

  // A scaled channel never grows
  for (genvar k = 0; k < LANES; k++) begin : g_chk
    a_no_growth : assert property (@(posedge clk) disable iff (!rst_n)
      vld[DIV_STAGES] && last.scaled |-> last.quot[k] <= last.chan[k])
      else $error("scaled channel above its input");
  end

endmodule

@@ dv/tb.sv @@
module tb;
  import brc_pkg::*;

  // Pipeline depth of the block, and the longest stretch without any handshake
  localparam int PIPE_LAT     = CH_BITS + 2;
  localparam int QUIET_LIMIT  = 5000;
  localparam int HOLD_CYCLES  = 80;
  localparam int SEG_ITEMS    = 75;
  localparam int REPORT_MAX   = 10;
  localparam int CHAN_MAX     = (1 << CH_BITS) - 1;
  localparam int LIMIT_MAX    = (1 << LIMIT_BITS) - 1;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
  } pix_word_t;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
    logic  scaled;
  } clamp_res_t;

  logic   clk = 1'b0;
  logic   rst_n;
  logic   cfg_we;
  limit_t cfg_data;

  brc_pix_if pix_if ();
  brc_res_if res_if ();

  rgb_total_brightness_clamp_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (pix_if.sink),
    .out_ch   (res_if.source),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  // Pending input words, expected result words, and the limit the block holds
  pix_word_t  pixel_backlog[$];
  clamp_res_t expected_pixels[$];
  limit_t     limit_now;

  int  src_idle_pct;
  int  snk_stall_pct;
  bit  hold_req;
  int  hold_left;
  bit  pix_taken;
  int  fail_cnt;
  int  quiet_cycles;
  pix_word_t  next_pix;
  clamp_res_t want;
  clamp_res_t got;
  limit_t     seg_limit[8];

  always #10 clk = ~clk;

  // Scale one channel by limit over sum, truncated towards zero.
  function automatic chan_t scale_chan(chan_t c, limit_t lim, sum_t total);
    logic [PROD_BITS-1:0] prod;
    prod = PROD_BITS'(c) * PROD_BITS'(lim);
    return chan_t'(prod / PROD_BITS'(total));
  endfunction

  // Work out the clamped pixel for one input word under the given limit.
  function automatic clamp_res_t clamp_pixel(chan_t r, chan_t g, chan_t b, limit_t lim);
    sum_t       total;
    clamp_res_t res;
    total = sum_t'(r) + sum_t'(g) + sum_t'(b);
    if (total <= sum_t'(lim)) begin
      res = '{red: r, green: g, blue: b, scaled: 1'b0};
    end else begin
      res.red    = scale_chan(r, lim, total);
      res.green  = scale_chan(g, lim, total);
      res.blue   = scale_chan(b, lim, total);
      res.scaled = 1'b1;
    end
    return res;
  endfunction

  // Random pixel: full range, dim, saturated corners, or a sum close to the limit.
  function automatic pix_word_t rand_pixel(limit_t lim);
    pix_word_t p;
    int target;
    int rest;
    int hi;
    case ($urandom_range(0, 3))
      0: begin
        p = '{red: chan_t'($urandom), green: chan_t'($urandom), blue: chan_t'($urandom)};
      end
      1: begin
        p = '{red: chan_t'($urandom_range(0, 15)), green: chan_t'($urandom_range(0, 15)),
              blue: chan_t'($urandom_range(0, 15))};
      end
      2: begin
        p.red   = $urandom_range(0, 1) ? chan_t'(CHAN_MAX) : chan_t'($urandom_range(0, 1));
        p.green = $urandom_range(0, 1) ? chan_t'(CHAN_MAX) : chan_t'($urandom);
        p.blue  = $urandom_range(0, 1) ? chan_t'(0) : chan_t'($urandom);
      end
      default: begin
        target = int'(lim) + $urandom_range(0, 4) - 2;
        if (target < 0) target = 0;
        if (target > 3 * CHAN_MAX) target = 3 * CHAN_MAX;
        hi = (target > CHAN_MAX) ? CHAN_MAX : target;
        p.red = chan_t'($urandom_range(0, hi));
        rest = target - int'(p.red);
        if (rest > 2 * CHAN_MAX) begin
          p.red = chan_t'(int'(p.red) + rest - 2 * CHAN_MAX);
          rest  = 2 * CHAN_MAX;
        end
        hi = (rest > CHAN_MAX) ? CHAN_MAX : rest;
        p.green = chan_t'($urandom_range((rest > CHAN_MAX) ? rest - CHAN_MAX : 0, hi));
        p.blue  = chan_t'(rest - int'(p.green));
      end
    endcase
    return p;
  endfunction

  task automatic add_pixel(int r, int g, int b);
    pixel_backlog.push_back('{red: chan_t'(r), green: chan_t'(g), blue: chan_t'(b)});
  endtask

  // Let the backlog empty and every result come back, then allow the pipe to settle.
  task automatic drain_all();
    while (pixel_backlog.size() != 0 || pix_if.valid) @(posedge clk);
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 4) @(posedge clk);
  endtask

  // Write the clamp limit while the block is idle.
  task automatic set_limit(limit_t v);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    limit_now = v;
    @(negedge clk);
    cfg_we   <= 1'b0;
  endtask

  // Sender: offers the next word from the backlog, idling at random.
  always @(negedge clk) begin
    if (!rst_n) begin
      pix_if.valid <= 1'b0;
    end else if (!pix_if.valid || pix_taken) begin
      if (pixel_backlog.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
        next_pix = pixel_backlog.pop_front();
        pix_if.red_in   <= next_pix.red;
        pix_if.green_in <= next_pix.green;
        pix_if.blue_in  <= next_pix.blue;
        pix_if.valid    <= 1'b1;
      end else begin
        pix_if.valid <= 1'b0;
      end
    end
  end

  // Receiver: stalls at random, or holds off for a long stretch on request.
  always @(negedge clk) begin
    if (!rst_n) begin
      res_if.ready <= 1'b0;
    end else begin
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
      end
    end
  end

  // Monitor: predicts each accepted input word and checks each accepted result word.
  always @(posedge clk) begin
    if (!rst_n) begin
      pix_taken    = 1'b0;
      quiet_cycles = 0;
    end else begin
      pix_taken = pix_if.valid && pix_if.ready;
      if (pix_taken) begin
        expected_pixels.push_back(clamp_pixel(pix_if.red_in, pix_if.green_in,
                                              pix_if.blue_in, limit_now));
      end
      if (res_if.valid && res_if.ready) begin
        got = '{red: res_if.red_out, green: res_if.green_out, blue: res_if.blue_out,
                scaled: res_if.was_scaled};
        if (expected_pixels.size() == 0) begin
          if (fail_cnt < REPORT_MAX) begin
            $display("%0t: result word with nothing expected: r=%0d g=%0d b=%0d s=%0b",
                     $time, got.red, got.green, got.blue, got.scaled);
          end
          fail_cnt++;
        end else begin
          want = expected_pixels.pop_front();
          if (got !== want) begin
            if (fail_cnt < REPORT_MAX) begin
              $display("%0t: mismatch: expected r=%0d g=%0d b=%0d s=%0b, got r=%0d g=%0d b=%0d s=%0b",
                       $time, want.red, want.green, want.blue, want.scaled,
                       got.red, got.green, got.blue, got.scaled);
            end
            fail_cnt++;
          end
        end
      end
      // Watchdog on cycles without any handshake.
      if (pix_taken || (res_if.valid && res_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("CHECK FAILED");
          $finish;
        end
      end
    end
  end

  // Stimulus sequence.
  initial begin
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_data        = '0;
    pix_if.valid    = 1'b0;
    pix_if.red_in   = '0;
    pix_if.green_in = '0;
    pix_if.blue_in  = '0;
    res_if.ready    = 1'b0;
    src_idle_pct    = 0;
    snk_stall_pct   = 0;
    hold_req        = 1'b0;
    hold_left       = 0;
    fail_cnt        = 0;
    limit_now       = LIMIT_RESET;
    seg_limit = '{limit_t'(LIMIT_MAX), limit_t'(0), limit_t'(3 * CHAN_MAX),
                  limit_t'(3 * CHAN_MAX - 1), limit_t'(1), limit_t'($urandom_range(0, LIMIT_MAX)),
                  limit_t'($urandom_range(0, 3 * CHAN_MAX)), LIMIT_RESET};

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset limit: extremes, single channels, and sums either side of the limit.
    add_pixel(0, 0, 0);
    add_pixel(255, 255, 255);
    add_pixel(255, 0, 0);
    add_pixel(0, 255, 0);
    add_pixel(0, 0, 255);
    add_pixel(85, 85, 85);
    add_pixel(85, 85, 86);
    add_pixel(128, 64, 63);
    add_pixel(128, 64, 64);
    add_pixel(1, 2, 3);
    add_pixel(254, 1, 0);
    drain_all();

    // A zero limit blanks every pixel but a black one.
    set_limit(limit_t'(0));
    add_pixel(0, 0, 0);
    add_pixel(1, 0, 0);
    add_pixel(0, 0, 1);
    add_pixel(255, 255, 255);
    drain_all();

    // The top limit lets everything through.
    set_limit(limit_t'(LIMIT_MAX));
    add_pixel(255, 255, 255);
    add_pixel(0, 0, 0);
    drain_all();

    // Random segments: two limits for each idling pattern.
    for (int seg = 0; seg < 8; seg++) begin
      set_limit(seg_limit[seg]);
      case (seg / 2)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 73; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 73; end
        default: begin src_idle_pct = 31; snk_stall_pct = 31; end
      endcase
      // Long receiver hold-off while words keep coming, so the pipe backs up.
      if (seg == 0) begin
        @(posedge clk);
        hold_req = 1'b1;
      end
      for (int n = 0; n < SEG_ITEMS; n++) pixel_backlog.push_back(rand_pixel(limit_now));
      // The sender pauses here until every result has come back.
      drain_all();
      for (int n = 0; n < SEG_ITEMS; n++) pixel_backlog.push_back(rand_pixel(limit_now));
      drain_all();
    end

    repeat (2 * PIPE_LAT) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
